// ===== rtl/core/tlca_pkg.sv =====
`default_nettype none

package tlca_pkg;

  localparam int FIELD_W     = 10;
  localparam int LIM_W       = 17;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [FIELD_W-1:0] field_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_LCA   = 2'd2,
    OP_ANC   = 2'd3
  } op_e;

  typedef struct packed {
    op_e    op;
    field_t node_a;
    field_t node_b;
    field_t node_level;
    field_t steps_up;
    logic   a_ok;
    logic   b_ok;
    logic   k_over;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  // Node 0 and nodes at or above the limit stand for none.
  function automatic logic node_ok(field_t n, logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] nx;
    nx = LIM_W'(n);
    return (n != '0) && (nx < lim);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tlca_ram.sv =====
`default_nettype none

module tlca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                      rdata_a_o,
  output logic [WIDTH-1:0]                      rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlca_front.sv =====
`default_nettype none

module tlca_front import tlca_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [1:0] opcode_i,
  input  field_t   node_a_i,
  input  field_t   node_b_i,
  input  field_t   node_level_i,
  input  field_t   steps_up_i,
  output cmd_req_t req_o,
  input  logic     pop_i
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [LIM_W-1:0] NODE_LIM = LIM_W'(MAX_NODES);
  localparam logic [LIM_W-1:0] STEP_LIM = LIM_W'(1) << LEVELS;

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          push, pop;
  cmd_t          cmd_in;

  always_comb begin
    cmd_in.op         = op_e'(opcode_i);
    cmd_in.node_a     = node_a_i;
    cmd_in.node_b     = node_b_i;
    cmd_in.node_level = node_level_i;
    cmd_in.steps_up   = steps_up_i;
    cmd_in.a_ok       = node_ok(node_a_i, NODE_LIM);
    cmd_in.b_ok       = node_ok(node_b_i, NODE_LIM);
    cmd_in.k_over     = LIM_W'(steps_up_i) >= STEP_LIM;
  end

  assign in_ready_o = cnt_q != (PW+1)'(QUEUE_DEPTH);
  assign push       = in_valid_i & in_ready_o;
  assign pop        = pop_i & (cnt_q != '0);
  assign req_o.valid = cnt_q != '0;
  assign req_o.cmd   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlca_back.sv =====
`default_nettype none

module tlca_back import tlca_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_req_t req_i,
  output logic     pop_o,
  input  field_t   node_count_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output field_t   result_node_o
);

  localparam int IDXW   = $clog2(MAX_NODES);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JAW    = LW + IDXW;
  localparam int JDEPTH = 2 ** JAW;
  localparam int DDEPTH = 2 ** IDXW;
  localparam int CW     = (IDXW > FIELD_W) ? IDXW : FIELD_W;
  localparam int KW     = 2 ** LW;

  localparam logic [LIM_W-1:0] NODE_LIM = LIM_W'(MAX_NODES);
  localparam logic [LW-1:0]    TOP_LVL  = LW'(LEVELS - 1);
  localparam logic [IDXW-1:0]  LAST_IDX = IDXW'(MAX_NODES - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_B_RD1  = 4'd1;
  localparam logic [3:0] S_B_RD2  = 4'd2;
  localparam logic [3:0] S_B_WR   = 4'd3;
  localparam logic [3:0] S_L_DEP  = 4'd4;
  localparam logic [3:0] S_L_UP1  = 4'd5;
  localparam logic [3:0] S_L_J1   = 4'd6;
  localparam logic [3:0] S_L_D1   = 4'd7;
  localparam logic [3:0] S_L_EQ   = 4'd8;
  localparam logic [3:0] S_L_UP2  = 4'd9;
  localparam logic [3:0] S_L_W2   = 4'd10;
  localparam logic [3:0] S_L_FIN  = 4'd11;
  localparam logic [3:0] S_L_FW   = 4'd12;
  localparam logic [3:0] S_A_STEP = 4'd13;
  localparam logic [3:0] S_A_W    = 4'd14;
  localparam logic [3:0] S_RES    = 4'd15;

  function automatic logic [IDXW-1:0] to_idx(field_t n);
    logic [IDXW+FIELD_W-1:0] w;
    w = {{IDXW{1'b0}}, n};
    return w[IDXW-1:0];
  endfunction

  logic [3:0]      state_q, state_d;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic [IDXW-1:0] idx_q, idx_d;
  field_t          a_q, a_d, b_q, b_d;
  field_t          da_q, da_d, db_q, db_d;
  field_t          k_q, k_d;
  field_t          res_q, res_d;
  logic            jok_a_q, jok_b_q, dok_a_q, dok_b_q;
  logic            out_valid_q, out_valid_d;
  field_t          out_q;
  logic            out_load;

  logic            jw_en;
  logic [JAW-1:0]  jw_addr;
  field_t          jw_data;
  logic            dw_en;
  logic [LW-1:0]   ja_lvl, jb_lvl;
  logic [IDXW-1:0] ja_idx, jb_idx, da_idx, db_idx;
  logic            ja_ok, jb_ok, da_ok, db_ok;
  field_t          jrd_a, jrd_b, drd_a, drd_b;
  field_t          jmp_a, jmp_b, dep_a, dep_b;

  logic [3:0]      adv_state;
  logic [LW-1:0]   adv_lvl;
  logic [IDXW-1:0] adv_idx;
  logic [KW+FIELD_W-1:0] k_wide;
  logic [KW-1:0]   k_x;
  logic            climb;

  tlca_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (JDEPTH)
  ) u_jump_ram (
    .clk_i     (clk_i),
    .we_i      (jw_en),
    .waddr_i   (jw_addr),
    .wdata_i   (jw_data),
    .raddr_a_i ({ja_lvl, ja_idx}),
    .raddr_b_i ({jb_lvl, jb_idx}),
    .rdata_a_o (jrd_a),
    .rdata_b_o (jrd_b)
  );

  tlca_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (DDEPTH)
  ) u_depth_ram (
    .clk_i     (clk_i),
    .we_i      (dw_en),
    .waddr_i   (to_idx(req_i.cmd.node_a)),
    .wdata_i   (req_i.cmd.node_level),
    .raddr_a_i (da_idx),
    .raddr_b_i (db_idx),
    .rdata_a_o (drd_a),
    .rdata_b_o (drd_b)
  );

  // reads of a node that stands for none return zero
  assign jmp_a = jok_a_q ? jrd_a : '0;
  assign jmp_b = jok_b_q ? jrd_b : '0;
  assign dep_a = dok_a_q ? drd_a : '0;
  assign dep_b = dok_b_q ? drd_b : '0;

  assign k_wide = {{KW{1'b0}}, k_q};
  assign k_x    = k_wide[KW-1:0];
  assign climb  = LIM_W'(da_q) >= LIM_W'(db_q) + (LIM_W'(1) << lvl_q);

  always_comb begin
    adv_state = S_B_RD1;
    adv_lvl   = lvl_q;
    adv_idx   = idx_q + IDXW'(1);
    if (idx_q == LAST_IDX) begin
      adv_idx = IDXW'(1);
      if (lvl_q == TOP_LVL) begin
        adv_state = S_IDLE;
      end else begin
        adv_lvl = lvl_q + LW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    idx_d   = idx_q;
    a_d     = a_q;
    b_d     = b_q;
    da_d    = da_q;
    db_d    = db_q;
    k_d     = k_q;
    res_d   = res_q;
    pop_o   = 1'b0;
    out_load = 1'b0;
    jw_en   = 1'b0;
    jw_addr = {lvl_q, idx_q};
    jw_data = '0;
    dw_en   = 1'b0;
    ja_lvl  = lvl_q;
    ja_idx  = to_idx(a_q);
    ja_ok   = 1'b0;
    jb_lvl  = lvl_q;
    jb_idx  = to_idx(b_q);
    jb_ok   = 1'b0;
    da_idx  = to_idx(req_i.cmd.node_a);
    da_ok   = 1'b0;
    db_idx  = to_idx(req_i.cmd.node_b);
    db_ok   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          pop_o = 1'b1;
          a_d   = req_i.cmd.node_a;
          b_d   = req_i.cmd.node_b;
          k_d   = req_i.cmd.steps_up;
          lvl_d = TOP_LVL;
          case (req_i.cmd.op)
            OP_LOAD: begin
              if (req_i.cmd.a_ok) begin
                jw_en   = 1'b1;
                jw_addr = {LW'(0), to_idx(req_i.cmd.node_a)};
                jw_data = req_i.cmd.node_b;
                dw_en   = 1'b1;
              end
            end
            OP_BUILD: begin
              if (LEVELS > 1) begin
                lvl_d   = LW'(1);
                idx_d   = IDXW'(1);
                state_d = S_B_RD1;
              end
            end
            OP_LCA: begin
              if (req_i.cmd.a_ok && req_i.cmd.b_ok) begin
                da_ok   = 1'b1;
                db_ok   = 1'b1;
                state_d = S_L_DEP;
              end else begin
                res_d   = '0;
                state_d = S_RES;
              end
            end
            OP_ANC: begin
              if (req_i.cmd.a_ok && !req_i.cmd.k_over) begin
                state_d = S_A_STEP;
              end else begin
                res_d   = '0;
                state_d = S_RES;
              end
            end
            default: ;
          endcase
        end
      end

      S_B_RD1: begin
        if (CW'(idx_q) <= CW'(node_count_i)) begin
          ja_lvl  = lvl_q - LW'(1);
          ja_idx  = idx_q;
          ja_ok   = 1'b1;
          state_d = S_B_RD2;
        end else begin
          jw_en   = 1'b1;
          state_d = adv_state;
          lvl_d   = adv_lvl;
          idx_d   = adv_idx;
        end
      end

      S_B_RD2: begin
        ja_lvl  = lvl_q - LW'(1);
        ja_idx  = to_idx(jmp_a);
        ja_ok   = node_ok(jmp_a, NODE_LIM);
        state_d = S_B_WR;
      end

      S_B_WR: begin
        jw_en   = 1'b1;
        jw_data = jmp_a;
        state_d = adv_state;
        lvl_d   = adv_lvl;
        idx_d   = adv_idx;
      end

      S_L_DEP: begin
        if (dep_a < dep_b) begin
          a_d  = b_q;
          b_d  = a_q;
          da_d = dep_b;
          db_d = dep_a;
        end else begin
          da_d = dep_a;
          db_d = dep_b;
        end
        state_d = S_L_UP1;
      end

      // lift the deeper node to the depth of the other
      S_L_UP1: begin
        if (climb) begin
          ja_ok   = node_ok(a_q, NODE_LIM);
          state_d = S_L_J1;
        end else if (lvl_q == '0) begin
          state_d = S_L_EQ;
        end else begin
          lvl_d = lvl_q - LW'(1);
        end
      end

      S_L_J1: begin
        a_d     = jmp_a;
        da_idx  = to_idx(jmp_a);
        da_ok   = node_ok(jmp_a, NODE_LIM);
        state_d = S_L_D1;
      end

      S_L_D1: begin
        da_d = dep_a;
        if (lvl_q == '0) begin
          state_d = S_L_EQ;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = S_L_UP1;
        end
      end

      S_L_EQ: begin
        if (a_q == b_q) begin
          res_d   = a_q;
          state_d = S_RES;
        end else begin
          lvl_d   = TOP_LVL;
          state_d = S_L_UP2;
        end
      end

      // lift both while their ancestors differ
      S_L_UP2: begin
        ja_ok   = node_ok(a_q, NODE_LIM);
        jb_ok   = node_ok(b_q, NODE_LIM);
        state_d = S_L_W2;
      end

      S_L_W2: begin
        if (jmp_a != '0 && jmp_a != jmp_b) begin
          a_d = jmp_a;
          b_d = jmp_b;
        end
        if (lvl_q == '0) begin
          state_d = S_L_FIN;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = S_L_UP2;
        end
      end

      S_L_FIN: begin
        ja_lvl  = '0;
        ja_ok   = node_ok(a_q, NODE_LIM);
        state_d = S_L_FW;
      end

      S_L_FW: begin
        res_d   = jmp_a;
        state_d = S_RES;
      end

      S_A_STEP: begin
        if (k_x[lvl_q]) begin
          ja_ok   = node_ok(a_q, NODE_LIM);
          state_d = S_A_W;
        end else if (lvl_q == '0) begin
          res_d   = a_q;
          state_d = S_RES;
        end else begin
          lvl_d = lvl_q - LW'(1);
        end
      end

      S_A_W: begin
        a_d = jmp_a;
        if (lvl_q == '0) begin
          res_d   = jmp_a;
          state_d = S_RES;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = S_A_STEP;
        end
      end

      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    idx_q   <= idx_d;
    a_q     <= a_d;
    b_q     <= b_d;
    da_q    <= da_d;
    db_q    <= db_d;
    k_q     <= k_d;
    res_q   <= res_d;
    jok_a_q <= ja_ok;
    jok_b_q <= jb_ok;
    dok_a_q <= da_ok;
    dok_b_q <= db_ok;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_node_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/tree_lca_binary_lifting_unit.sv =====
// channel  dir  handshake                 words carried
// in       in   in_valid_i / in_ready_o   opcode_i node_a_i node_b_i node_level_i steps_up_i
// out      out  out_valid_o / out_ready_i result_node_o
// cfg      in   cfg_we_i (no wait)        cfg_wdata_i -> node_count
//
// The single lifting engine takes one word at a time after the queue; each step makes one
// dependent registered read of the jump table.
// Reset clears control and sets node_count to 1; tables are not cleared.
// A 2-word queue decouples input from the engine; a result register holds the answer
// while out_ready_i is low, and the engine waits only when that register is full.
`default_nettype none

module tree_lca_binary_lifting_unit import tlca_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  field_t     node_a_i,
  input  field_t     node_b_i,
  input  field_t     node_level_i,
  input  field_t     steps_up_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output field_t     result_node_o,
  input  logic       cfg_we_i,
  input  field_t     cfg_wdata_i
);

  field_t   node_count_q;
  cmd_req_t req;
  logic     pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= FIELD_W'(1);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  tlca_front #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .node_a_i     (node_a_i),
    .node_b_i     (node_b_i),
    .node_level_i (node_level_i),
    .steps_up_i   (steps_up_i),
    .req_o        (req),
    .pop_i        (pop)
  );

  tlca_back #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .pop_o         (pop),
    .node_count_i  (node_count_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_node_o (result_node_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tlca_checker.sv =====
`default_nettype none

module tlca_checker import tlca_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_ready_o,
  input logic   out_valid_o,
  input logic   out_ready_i,
  input field_t result_node_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_node_o))
    else $error("result word changed while stalled");

  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result word straight after reset");

  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("queue filled without an input word");

endmodule

bind tree_lca_binary_lifting_unit tlca_checker u_tlca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_node_o (result_node_o)
);

`default_nettype wire

// ===== tb/tb_tree_lca_binary_lifting_unit.sv =====
`default_nettype none

module tb_tree_lca_binary_lifting_unit;
  import tlca_pkg::*;

  localparam int MAX_NODES   = 1024;
  localparam int LEVELS      = 10;
  localparam int IDLE_PCT    = 23;
  localparam int STALL_LIMIT = 150000;

  // Shadow of the lifting engine: parents, depths, node_count and the answers owed.
  class ancestor_board;
    bit [FIELD_W-1:0] jump_tab[LEVELS][MAX_NODES];
    bit [FIELD_W-1:0] depth_tab[MAX_NODES];
    int unsigned      node_limit;
    field_t           answer_q[$];
    int               errors, words, loads, builds, queries, compared, settings;

    function new();
      node_limit = 1;
    endfunction

    function bit live(int unsigned n);
      return n != 0 && n < MAX_NODES;
    endfunction

    function int unsigned hop(int unsigned lvl, int unsigned n);
      if (!live(n) || lvl >= LEVELS) return 0;
      return jump_tab[lvl][n];
    endfunction

    function int depth_at(int unsigned n);
      if (!live(n)) return 0;
      return int'(depth_tab[n]);
    endfunction

    function void rebuild();
      int unsigned last;
      last = (node_limit > MAX_NODES - 1) ? MAX_NODES - 1 : node_limit;
      for (int j = 1; j < LEVELS; j++)
        for (int i = 1; i < MAX_NODES; i++)
          jump_tab[j][i] = (i <= last) ? hop(j - 1, hop(j - 1, i)) : 0;
    endfunction

    function int unsigned common_ancestor(int unsigned a, int unsigned b);
      int unsigned t, pa, pb;
      if (!live(a) || !live(b)) return 0;
      if (depth_at(a) < depth_at(b)) begin
        t = a;
        a = b;
        b = t;
      end
      for (int i = LEVELS - 1; i >= 0; i--)
        if (depth_at(a) - (1 << i) >= depth_at(b)) a = hop(i, a);
      if (a == b) return a;
      for (int i = LEVELS - 1; i >= 0; i--) begin
        pa = hop(i, a);
        pb = hop(i, b);
        if (pa != 0 && pa != pb) begin
          a = pa;
          b = pb;
        end
      end
      return hop(0, a);
    endfunction

    function int unsigned climb(int unsigned a, int unsigned k);
      if (!live(a) || k >= (1 << LEVELS)) return 0;
      for (int i = LEVELS - 1; i >= 0; i--)
        if (k >= (1 << i)) begin
          a = hop(i, a);
          k -= (1 << i);
        end
      return a;
    endfunction

    function void set_limit(int unsigned n);
      node_limit = n;
      settings++;
    endfunction

    function void owe(field_t v);
      answer_q = {answer_q, v};
    endfunction

    function void note_word(op_e op, int unsigned a, b, lvl, k);
      words++;
      case (op)
        OP_LOAD: begin
          loads++;
          if (live(a)) begin
            jump_tab[0][a] = b;
            depth_tab[a]   = lvl;
          end
        end
        OP_BUILD: begin
          builds++;
          rebuild();
        end
        OP_LCA: begin
          queries++;
          owe(field_t'(common_ancestor(a, b)));
        end
        default: begin
          queries++;
          owe(field_t'(climb(a, k)));
        end
      endcase
    endfunction

    function void check_result(field_t got);
      field_t want;
      if (answer_q.size() == 0) begin
        errors++;
        $display("%0t: result_node expected none, got %0d", $time, got);
        return;
      end
      want = answer_q.pop_front();
      compared++;
      if (got !== want) begin
        errors++;
        $display("%0t: result_node expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return answer_q.size();
    endfunction
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [1:0] opcode_i     = OP_LOAD;
  field_t     node_a_i     = '0;
  field_t     node_b_i     = '0;
  field_t     node_level_i = '0;
  field_t     steps_up_i   = '0;
  logic       out_ready_i  = 1'b0;
  logic       cfg_we_i     = 1'b0;
  field_t     cfg_wdata_i  = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  field_t     result_node_o;

  ancestor_board sb = new();
  bit            no_idle;
  int            stall_cycles;
  bit            loaded[MAX_NODES];
  int            tree_depth[MAX_NODES];

  tree_lca_binary_lifting_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .node_level_i  (node_level_i),
    .steps_up_i    (steps_up_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_node_o (result_node_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(result_node_o);
  end

  // receiver stalls and the no-progress watchdog
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input op_e op, input int a, b, lvl, k);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    node_a_i     <= field_t'(a);
    node_b_i     <= field_t'(b);
    node_level_i <= field_t'(lvl);
    steps_up_i   <= field_t'(k);
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_word(op, field_t'(a), field_t'(b), field_t'(lvl), field_t'(k));
  endtask

  task automatic wait_quiet(input int hold);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (hold) @(posedge clk_i);
  endtask

  task automatic set_node_count(input int n);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= field_t'(n);
    @(posedge clk_i);
    sb.set_limit(n);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_node(input int n, p, lvl);
    send_word(OP_LOAD, n, p, lvl, $urandom_range(0, 1023));
    loaded[n]     = 1'b1;
    tree_depth[n] = lvl;
  endtask

  function automatic int next_level(int p);
    if ($urandom_range(0, 19) == 0) return $urandom_range(1, 1023);
    if (p == 0) return 1;
    return (tree_depth[p] >= 1023) ? 1023 : tree_depth[p] + 1;
  endfunction

  function automatic int pick_loaded();
    int n;
    do n = $urandom_range(1, MAX_NODES - 1); while (!loaded[n]);
    return n;
  endfunction

  function automatic int pick_node(int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 20) return pick_loaded();
    return $urandom_range(1, n);
  endfunction

  // fresh tree on 1..n, build, then mixed queries and re-parenting
  task automatic run_phase(input int n, input int items, input bit mid_build, input int hold_at);
    int a, b, p, r;
    set_node_count(n);
    for (int i = 1; i <= n; i++) begin
      if (i == 1 || $urandom_range(0, 19) == 0) p = 0;
      else if ($urandom_range(0, 2) == 0) p = $urandom_range(1, i - 1);
      else p = $urandom_range((i > 3) ? i - 3 : 1, i - 1);
      load_node(i, p, next_level(p));
    end
    send_word(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
    for (int i = 0; i < items; i++) begin
      if (i == hold_at) wait_quiet(0);
      if (mid_build && i == items / 2)
        send_word(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
      r = $urandom_range(0, 99);
      if (r < 44) begin
        send_word(OP_LCA, pick_node(n), pick_node(n), $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
      end else if (r < 80) begin
        a = pick_node(n);
        b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, tree_depth[a] + 1);
        send_word(OP_ANC, a, $urandom_range(0, 1023), $urandom_range(0, 1023), b);
      end else if (r < 94) begin
        a = ($urandom_range(0, 4) == 0) ? pick_loaded() : $urandom_range(1, n);
        p = ($urandom_range(0, 9) == 0) ? 0 : pick_loaded();
        load_node(a, p, next_level(p));
      end else begin
        send_word(OP_LOAD, 0, $urandom_range(0, 1023), $urandom_range(1, 1023),
                  $urandom_range(0, 1023));
      end
    end
    // a query last, so its answer proves the engine has finished
    send_word(OP_ANC, $urandom_range(1, n), $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
    wait_quiet(64);
  endtask

  initial begin
    int dir_parent[9];
    int dir_depth[9];
    dir_parent = '{0, 0, 1, 1, 2, 2, 4, 6, 3};
    dir_depth  = '{0, 1, 2, 2, 3, 3, 4, 5, 3};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small hand-built tree, node 1023 hangs below node 8 outside node_count
    set_node_count(8);
    send_word(OP_LOAD, 0, 5, 3, 0);
    for (int i = 1; i <= 8; i++) load_node(i, dir_parent[i], dir_depth[i]);
    load_node(1023, 8, 1023);
    send_word(OP_BUILD, 1023, 1023, 1023, 1023);
    send_word(OP_LCA, 7, 5, 1, 0);
    send_word(OP_LCA, 7, 8, 1023, 1023);
    send_word(OP_LCA, 4, 7, 1, 0);
    send_word(OP_LCA, 6, 6, 1, 0);
    send_word(OP_LCA, 0, 5, 1, 0);
    send_word(OP_LCA, 5, 0, 1, 0);
    send_word(OP_LCA, 5, 1023, 1, 0);
    send_word(OP_ANC, 7, 0, 1, 0);
    send_word(OP_ANC, 7, 0, 1, 3);
    send_word(OP_ANC, 7, 0, 1, 5);
    send_word(OP_ANC, 7, 1023, 1023, 1023);
    send_word(OP_ANC, 0, 0, 1, 1);
    send_word(OP_ANC, 1023, 0, 1, 1);
    send_word(OP_ANC, 1023, 0, 1, 2);
    wait_quiet(64);

    run_phase($urandom_range(200, 300), 70, 1'b1, -1);
    run_phase(1, 70, 1'b0, 30);
    no_idle = 1'b1;
    run_phase($urandom_range(2, 12), 70, 1'b1, -1);
    no_idle = 1'b0;
    run_phase($urandom_range(13, 60), 70, 1'b0, -1);
    run_phase($urandom_range(61, 150), 70, 1'b1, -1);

    $display("Sent %0d words: %0d loads, %0d table builds, %0d LCA/ancestor queries",
             sb.words, sb.loads, sb.builds, sb.queries);
    $display("Compared %0d answers over %0d node_count settings", sb.compared, sb.settings);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
